FILE: rtl/piecewise_linear_table_interpolator_assert.svh
// Assertion macros for the table interpolator
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
// Implication checked every clock, off during reset
`define PLTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, off during reset
`define PLTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/plti_pkg.sv
//------------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise linear table interpolator.
//------------------------------------------------------------------------------
`default_nettype none
package plti_pkg;
    localparam int MaxPoints = 16;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int DataW     = 16;
    localparam int QDepth    = 2;

    typedef enum logic [1:0] {
        REG_EMPTY = 2'd0,
        REG_INSIDE = 2'd1,
        REG_BELOW = 2'd2,
        REG_ABOVE = 2'd3
    } t_region;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_CMP, ST_MUL, ST_DIV, ST_FIX, ST_DONE
    } t_state;

    // Evaluate request travelling from the front to the back
    typedef struct packed {
        logic signed [DataW-1:0] qx;
        logic [CntW-1:0]         n;
    } t_eval_req;
endpackage
`default_nettype wire

FILE: rtl/plti_front.sv
//------------------------------------------------------------------------------
// plti_front
// Accepts requests, writes breakpoints, queues evaluate requests.
//------------------------------------------------------------------------------
`default_nettype none
module plti_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              push,
    output logic                             full,
    input  wire                              i_req_type,
    input  wire  [plti_pkg::IdxW-1:0]        i_point_index,
    input  wire  signed [plti_pkg::DataW-1:0] i_point_x,
    input  wire  signed [plti_pkg::DataW-1:0] i_point_y,
    input  wire  signed [plti_pkg::DataW-1:0] i_query_x,
    input  wire  [plti_pkg::CntW-1:0]        i_count,
    output logic                             o_wr_en,
    output logic [plti_pkg::IdxW-1:0]        o_wr_idx,
    output logic [2*plti_pkg::DataW-1:0]     o_wr_data,
    output logic                             o_q_valid,
    output plti_pkg::t_eval_req              o_q_req,
    input  wire                              i_q_take,
    input  wire                              i_back_busy
);
    import plti_pkg::*;

    t_eval_req r_q [QDepth];
    t_eval_req n_q0, n_q1;
    logic [$clog2(QDepth+1)-1:0] r_cnt, n_cnt;
    logic acc, put, wpos;
    logic [CntW-1:0] nclip;

    // a write waits until every queued or running evaluate has finished
    assign full = (r_cnt == QDepth[$clog2(QDepth+1)-1:0])
                  || (!i_req_type && ((r_cnt != '0) || i_back_busy));
    assign acc  = push && !full;
    assign put  = acc && i_req_type;
    // clip the count to the table size
    assign nclip = (i_count > MaxPoints[CntW-1:0]) ? MaxPoints[CntW-1:0] : i_count;

    assign o_wr_en   = acc && !i_req_type;
    assign o_wr_idx  = i_point_index;
    assign o_wr_data = {i_point_x, i_point_y};
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_q[0];

    // slot of the new entry after the shift
    assign wpos = r_cnt[0] ^ i_q_take;

    always_comb begin
        n_cnt = r_cnt + {{($clog2(QDepth+1)-1){1'b0}}, put}
                      - {{($clog2(QDepth+1)-1){1'b0}}, i_q_take};
        n_q0 = r_q[0];
        n_q1 = r_q[1];
        if (i_q_take) begin
            n_q0 = r_q[1];
        end
        if (put) begin
            if (wpos) begin
                n_q1 = '{qx: i_query_x, n: nclip};
            end else begin
                n_q0 = '{qx: i_query_x, n: nclip};
            end
        end
    end

    // two-entry shift queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q[1'b0] <= n_q0;
        r_q[1'b1] <= n_q1;
    end

    `include "piecewise_linear_table_interpolator_assert.svh"
    `PLTI_ASSERT_IMP(a_no_take_empty, i_clk, i_rst_n, i_q_take, o_q_valid, "take from empty queue")
    `PLTI_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= QDepth, "queue count overflow")
    `PLTI_ASSERT_NEXT(a_fill, i_clk, i_rst_n, put && !i_q_take, r_cnt != '0, "queue lost a push")
    `PLTI_ASSERT_IMP(a_wr_quiet, i_clk, i_rst_n, o_wr_en, !o_q_valid && !i_back_busy, "write busy")
endmodule
`default_nettype wire

FILE: rtl/plti_back.sv
//------------------------------------------------------------------------------
// plti_back
// Scans the segment table, multiplies and divides, holds one result.
//------------------------------------------------------------------------------
`default_nettype none
module plti_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_wr_en,
    input  wire  [plti_pkg::IdxW-1:0]        i_wr_idx,
    input  wire  [2*plti_pkg::DataW-1:0]     i_wr_data,
    input  wire                              i_q_valid,
    input  plti_pkg::t_eval_req              i_q_req,
    output logic                             o_q_take,
    output logic                             o_busy,
    output logic                             empty,
    input  wire                              pop,
    output logic signed [plti_pkg::DataW-1:0] o_result_y,
    output logic [plti_pkg::IdxW-1:0]        o_segment_used,
    output logic [1:0]                       o_region
);
    import plti_pkg::*;

    // breakpoint memory: {x, y}
    logic [2*DataW-1:0] r_mem [MaxPoints];
    logic [2*DataW-1:0] r_rd;
    logic [IdxW-1:0]    r_ra, n_ra;

    t_state r_st, n_st;
    logic signed [DataW-1:0] r_qx, r_x0, r_y0, r_xf, r_yf;
    logic [CntW-1:0]  r_n;
    logic [CntW-1:0]  r_i, n_i;       // index of entry arriving on r_rd
    logic signed [33:0] r_num;        // magnitude work in r_rem/r_quo
    logic [33:0] r_rem;
    logic [33:0] r_quo;
    logic [16:0] r_den;
    logic r_neg;
    logic [5:0] r_bit;
    logic signed [DataW-1:0] r_res;
    logic [IdxW-1:0] r_seg, r_res_seg;
    logic [1:0] r_reg, r_res_reg;
    logic r_full;

    logic signed [DataW-1:0] rx, ry;
    logic signed [16:0] dy, dq, dx;
    logic signed [33:0] prod;
    logic [34:0] trial;
    logic signed [18:0] sum;
    logic hit;

    assign rx = r_rd[2*DataW-1:DataW];
    assign ry = r_rd[DataW-1:0];
    assign empty = !r_full;
    assign o_result_y = r_res;
    assign o_segment_used = r_res_seg;
    assign o_region = r_res_reg;
    assign o_q_take = (r_st == ST_IDLE) && i_q_valid;
    assign o_busy = (r_st != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd <= r_mem[n_ra];
        r_ra <= n_ra;
    end

    // segment test against entry pair (r_x0, rx)
    assign hit = (r_qx >= r_x0) && (r_qx <= rx);
    assign dy  = 17'(ry) - 17'(r_y0);
    assign dq  = 17'(r_qx) - 17'(r_x0);
    assign dx  = 17'(rx) - 17'(r_x0);
    assign prod = 34'(dy) * 34'(dq);
    assign trial = {r_rem, r_quo[33]} - {18'd0, r_den};
    assign sum = 19'(r_y0) + (r_neg ? -19'(signed'(r_quo[17:0])) : 19'(signed'(r_quo[17:0])));

    always_comb begin
        n_st = r_st;
        n_ra = r_ra;
        n_i  = r_i;
        case (r_st)
            ST_IDLE: begin
                n_ra = '0;
                if (i_q_valid) begin
                    n_st = ST_RD;
                end
            end
            ST_RD: begin
                // entry 0 arrives on r_rd next cycle
                n_ra = '0;
                n_i  = '0;
                n_st = ST_CMP;
            end
            ST_CMP: begin
                n_ra = r_ra + 1'b1;
                n_i  = r_i + 1'b1;
                if (r_n == '0) begin
                    n_st = ST_DONE;
                end else if (r_i != '0 && hit) begin
                    n_st = ST_MUL;
                end else if (r_i + 1'b1 >= r_n) begin
                    n_st = ST_DONE;
                end
            end
            ST_MUL: n_st = ST_DIV;
            ST_DIV: if (r_bit == '0) n_st = ST_FIX;
            ST_FIX: n_st = ST_DONE;
            ST_DONE: if (!r_full || pop) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_full <= 1'b0;
        end else begin
            r_st <= n_st;
            if (pop && r_full) r_full <= 1'b0;
            if (r_st == ST_DONE && (!r_full || pop)) r_full <= 1'b1;
        end
        r_i <= n_i;
        case (r_st)
            ST_IDLE: begin
                r_qx <= i_q_req.qx;
                r_n  <= i_q_req.n;
            end
            ST_CMP: begin
                if (r_n == '0) begin
                    r_yf <= '0; r_seg <= '0; r_reg <= REG_EMPTY;
                end else if (r_i == '0) begin
                    r_xf <= rx; r_yf <= ry;
                    r_seg <= '0;
                    r_reg <= (r_qx < rx) ? REG_BELOW : REG_ABOVE;
                end else if (hit) begin
                    r_seg <= IdxW'(r_i - 1'b1);
                    r_reg <= REG_INSIDE;
                    r_yf  <= r_y0;
                    r_den <= dx;
                    r_num <= prod;
                end else begin
                    // clamp to last read entry unless below first
                    if (r_qx >= r_xf) r_yf <= ry;
                end
                r_x0 <= rx;
                r_y0 <= ry;
            end
            ST_MUL: begin
                // go to magnitudes
                r_neg <= r_num[33];
                r_quo <= r_num[33] ? 34'(-r_num) : r_num;
                r_rem <= '0;
                r_bit <= 6'd34;
                r_y0  <= r_yf;
            end
            ST_DIV: begin
                if (r_bit != '0) begin
                    r_bit <= r_bit - 1'b1;
                    if (r_den == '0) begin
                        r_quo <= '0;
                        r_bit <= '0;
                    end else if (!trial[34]) begin
                        r_rem <= trial[33:0];
                        r_quo <= {r_quo[32:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[32:0], r_quo[33]};
                        r_quo <= {r_quo[32:0], 1'b0};
                    end
                end
            end
            ST_FIX: begin
                if (r_quo[33:17] != '0) begin
                    r_yf <= r_neg ? -16'sd32768 : 16'sd32767;
                end else if (sum > 19'sd32767) begin
                    r_yf <= 16'sd32767;
                end else if (sum < -19'sd32768) begin
                    r_yf <= -16'sd32768;
                end else begin
                    r_yf <= sum[15:0];
                end
            end
            ST_DONE: begin
                // result register holds all fields until popped
                if (!r_full || pop) begin
                    r_res     <= r_yf;
                    r_res_seg <= r_seg;
                    r_res_reg <= r_reg;
                end
            end
            default: ;
        endcase
    end

    `include "piecewise_linear_table_interpolator_assert.svh"
    `PLTI_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_full && !pop, r_full && $stable(o_result_y), "result lost")
    `PLTI_ASSERT_IMP(a_seg0, i_clk, i_rst_n, r_full && o_region != REG_INSIDE, o_segment_used == '0, "seg")
    `PLTI_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_q_take, r_st == ST_IDLE, "take while busy")
endmodule
`default_nettype wire

FILE: rtl/piecewise_linear_table_interpolator.sv
//------------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Breakpoint table with linear interpolation between breakpoints.
//------------------------------------------------------------------------------
// Usage:
//  Input queue: present a request and raise push while full is low. A write
//  request stores one breakpoint and gives no result; an evaluate request
//  gives one result.
//  Result queue: while empty is low the result ports hold the oldest result;
//  pop takes it.
//  point_count is written on the cfg channel (cfg_valid/cfg_ready, always
//  ready); the user must write it only while the block is idle, which the
//  block itself does not enforce.
//  An evaluate reads one table entry per cycle from the breakpoint memory;
//  a matching segment then passes a 34-step restoring divider, which a
//  zero-width segment skips. Writes go straight into the breakpoint memory.
//  A two-entry queue parts the front from the back, so evaluates are taken
//  while a result waits; a write request waits (full high) until every
//  evaluate ahead of it has stored its result. A stalled receiver holds the
//  result and the back.
//  Reset (sync, active low) empties the queues and sets point_count to 0;
//  table contents stay undefined until written.
//------------------------------------------------------------------------------
`default_nettype none
module piecewise_linear_table_interpolator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               push,
    output logic                              full,
    input  wire                               i_req_type,
    input  wire  [3:0]                        i_point_index,
    input  wire  signed [plti_pkg::DataW-1:0] i_point_x,
    input  wire  signed [plti_pkg::DataW-1:0] i_point_y,
    input  wire  signed [plti_pkg::DataW-1:0] i_query_x,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [4:0]                        i_point_count,
    output logic                              empty,
    input  wire                               pop,
    output logic signed [plti_pkg::DataW-1:0] o_result_y,
    output logic [3:0]                        o_segment_used,
    output logic [1:0]                        o_region
);
    import plti_pkg::*;

    logic [4:0] r_count;
    logic wr_en, q_valid, q_take, back_busy;
    logic [IdxW-1:0] wr_idx;
    logic [2*DataW-1:0] wr_data;
    t_eval_req q_req;

    assign cfg_ready = 1'b1;
    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cfg_valid) begin
            r_count <= i_point_count;
        end
    end

    plti_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_req_type,
        .i_point_index(i_point_index), .i_point_x, .i_point_y, .i_query_x,
        .i_count(CntW'(r_count)),
        .o_wr_en(wr_en), .o_wr_idx(wr_idx), .o_wr_data(wr_data),
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_take(q_take),
        .i_back_busy(back_busy)
    );

    plti_back u_back (
        .i_clk, .i_rst_n, .i_wr_en(wr_en), .i_wr_idx(wr_idx), .i_wr_data(wr_data),
        .i_q_valid(q_valid), .i_q_req(q_req), .o_q_take(q_take), .o_busy(back_busy),
        .empty, .pop, .o_result_y, .o_segment_used, .o_region
    );
endmodule
`default_nettype wire
